/* rtl/core/ple_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and codes for the positional list engine.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
package ple_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int REQ_W = 3;
    localparam int POS_W = 8;
    localparam int KEY_W = 32;
    localparam int VAL_W = 64;
    localparam int ST_W  = 3;

    // stream word layouts, rounded up to whole bytes
    localparam int IN_BITS  = REQ_W + POS_W + KEY_W + VAL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = ST_W + POS_W + KEY_W + VAL_W + POS_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // cells are grouped for the first-match and gather trees
    localparam int GRP  = 16;
    localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [VAL_W-1:0] val_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND     = 3'd0,
        REQ_INSERT     = 3'd1,
        REQ_REMOVE_AT  = 3'd2,
        REQ_REMOVE_KEY = 3'd3,
        REQ_SEARCH     = 3'd4,
        REQ_READ       = 3'd5
    } req_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_BADPOS = 3'd2,
        ST_NOKEY  = 3'd3,
        ST_EMPTY  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_GRP,
        S_SEL,
        S_GATH,
        S_DONE
    } state_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic ins_en;
        idx_t ins_idx;
        key_t new_key;
        val_t new_val;
        logic del_en;
        logic hit_key_en;
        logic hit_pos_en;
        idx_t pos_idx;
        cnt_t count;
    } cell_ctrl_t;

endpackage

/* rtl/core/ple_cell.sv */
`timescale 1ns / 1ps
// One list slot: key/value storage, shift from either neighbor, hit flag.
// Depends on ple_pkg.
module ple_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  ple_pkg::idx_t      cell_idx,
    input  ple_pkg::cell_ctrl_t ctrl,
    input  ple_pkg::key_t      lower_key,
    input  ple_pkg::val_t      lower_val,
    input  ple_pkg::key_t      upper_key,
    input  ple_pkg::val_t      upper_val,
    input  logic               ge,
    output ple_pkg::key_t      key,
    output ple_pkg::val_t      val,
    output logic               hit
);

    ple_pkg::key_t key_reg, key_next;
    ple_pkg::val_t val_reg, val_next;
    logic          hit_reg, hit_next;

    always_comb
    begin
        key_next = key_reg;
        val_next = val_reg;
        if (ctrl.ins_en)
        begin
            if (cell_idx == ctrl.ins_idx)
            begin
                key_next = ctrl.new_key;
                val_next = ctrl.new_val;
            end
            else if (cell_idx > ctrl.ins_idx)
            begin
                key_next = lower_key;
                val_next = lower_val;
            end
        end
        else if (ctrl.del_en && ge)
        begin
            key_next = upper_key;
            val_next = upper_val;
        end

        hit_next = (ctrl.hit_key_en && (ple_pkg::CNT_W'(cell_idx) < ctrl.count)
                    && (key_reg == ctrl.new_key))
                || (ctrl.hit_pos_en && (cell_idx == ctrl.pos_idx));
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else
            hit_reg <= hit_next;
    end

    assign key = key_reg;
    assign val = val_reg;
    assign hit = hit_reg;

endmodule

/* rtl/core/ple_select.sv */
`timescale 1ns / 1ps
// Two-stage registered first-hit tree: one-hot select and at-or-after mask.
// Depends on ple_pkg.
module ple_select
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ple_pkg::CAPACITY-1:0]  hit,
    output logic [ple_pkg::CAPACITY-1:0]  sel,
    output logic [ple_pkg::CAPACITY-1:0]  ge,
    output logic                          any
);

    logic [ple_pkg::CAPACITY-1:0] first_reg, first_next;
    logic [ple_pkg::CAPACITY-1:0] lpre_reg, lpre_next;
    logic [ple_pkg::NGRP-1:0]     gany_reg, gany_next;
    logic [ple_pkg::CAPACITY-1:0] sel_reg, sel_next;
    logic [ple_pkg::CAPACITY-1:0] ge_reg, ge_next;
    logic                         any_reg, any_next;

    // stage 1: first hit and running OR inside each group
    always_comb
    begin
        logic seen;
        int   idx;
        first_next = '0;
        lpre_next  = '0;
        gany_next  = '0;
        for (int g = 0; g < ple_pkg::NGRP; g++)
        begin
            seen = 1'b0;
            for (int j = 0; j < ple_pkg::GRP; j++)
            begin
                idx = g * ple_pkg::GRP + j;
                if (idx < ple_pkg::CAPACITY)
                begin
                    first_next[idx] = hit[idx] & ~seen;
                    seen            = seen | hit[idx];
                    lpre_next[idx]  = seen;
                end
            end
            gany_next[g] = seen;
        end
    end

    // stage 2: mask by hits in earlier groups
    always_comb
    begin
        logic earlier;
        int   idx;
        sel_next = '0;
        ge_next  = '0;
        earlier  = 1'b0;
        for (int g = 0; g < ple_pkg::NGRP; g++)
        begin
            for (int j = 0; j < ple_pkg::GRP; j++)
            begin
                idx = g * ple_pkg::GRP + j;
                if (idx < ple_pkg::CAPACITY)
                begin
                    sel_next[idx] = first_reg[idx] & ~earlier;
                    ge_next[idx]  = lpre_reg[idx] | earlier;
                end
            end
            earlier = earlier | gany_reg[g];
        end
        any_next = earlier;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            lpre_reg  <= '0;
            gany_reg  <= '0;
            sel_reg   <= '0;
            ge_reg    <= '0;
            any_reg   <= 1'b0;
        end
        else
        begin
            first_reg <= first_next;
            lpre_reg  <= lpre_next;
            gany_reg  <= gany_next;
            sel_reg   <= sel_next;
            ge_reg    <= ge_next;
            any_reg   <= any_next;
        end
    end

    assign sel = sel_reg;
    assign ge  = ge_reg;
    assign any = any_reg;

endmodule

/* rtl/core/ple_gather.sv */
`timescale 1ns / 1ps
// Gathers position, key and value of the one selected cell: registered
// OR per group, then an OR across groups. Depends on ple_pkg.
module ple_gather
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [ple_pkg::CAPACITY-1:0]  sel,
    input  ple_pkg::key_t                 keys [ple_pkg::CAPACITY],
    input  ple_pkg::val_t                 vals [ple_pkg::CAPACITY],
    output ple_pkg::pos_t                 pos,
    output ple_pkg::key_t                 key,
    output ple_pkg::val_t                 val
);

    ple_pkg::pos_t gpos_reg [ple_pkg::NGRP];
    ple_pkg::key_t gkey_reg [ple_pkg::NGRP];
    ple_pkg::val_t gval_reg [ple_pkg::NGRP];
    ple_pkg::pos_t gpos_next [ple_pkg::NGRP];
    ple_pkg::key_t gkey_next [ple_pkg::NGRP];
    ple_pkg::val_t gval_next [ple_pkg::NGRP];

    always_comb
    begin
        int idx;
        for (int g = 0; g < ple_pkg::NGRP; g++)
        begin
            gpos_next[g] = '0;
            gkey_next[g] = '0;
            gval_next[g] = '0;
            for (int j = 0; j < ple_pkg::GRP; j++)
            begin
                idx = g * ple_pkg::GRP + j;
                if (idx < ple_pkg::CAPACITY && sel[idx])
                begin
                    gpos_next[g] = gpos_next[g] | ple_pkg::POS_W'(idx + 1);
                    gkey_next[g] = gkey_next[g] | keys[idx];
                    gval_next[g] = gval_next[g] | vals[idx];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gpos_reg <= gpos_next;
            gkey_reg <= gkey_next;
            gval_reg <= gval_next;
        end
    end

    always_comb
    begin
        pos = '0;
        key = '0;
        val = '0;
        for (int g = 0; g < ple_pkg::NGRP; g++)
        begin
            pos = pos | gpos_reg[g];
            key = key | gkey_reg[g];
            val = val | gval_reg[g];
        end
    end

endmodule

/* rtl/core/positional_list_engine.sv */
`timescale 1ns / 1ps
// Positional list engine: packed key/value list held in a row of cells.
// Each accepted word walks through the compare, two-stage first-hit tree and
// gather stages, then waits in the done state until the output register can
// take its result word; a new word is accepted only after that result is
// loaded. The output register lets a new word in while a result still waits.
// Reset empties the list (count zero); cell contents are not cleared.
// Depends on ple_pkg, ple_cell, ple_select, ple_gather.
module positional_list_engine
(
    input  logic                       clk,
    input  logic                       rst_n,
    // s_tdata: req_type[2:0], position[10:3], entry_key[42:11],
    //          entry_value[106:43], zero pad
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ple_pkg::IN_W-1:0]   s_tdata,
    // m_tdata: status[2:0], found_position[10:3], read_key[42:11],
    //          read_value[106:43], entry_count[114:107], zero pad
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ple_pkg::OUT_W-1:0]  m_tdata
);

    localparam int CW = ((ple_pkg::CNT_W > ple_pkg::POS_W) ?
                         ple_pkg::CNT_W : ple_pkg::POS_W) + 1;

    ple_pkg::state_t state_reg, state_next;

    logic [ple_pkg::REQ_W-1:0] req_reg;
    ple_pkg::pos_t             pos_reg;
    ple_pkg::key_t             key_reg;
    ple_pkg::val_t             val_reg;
    ple_pkg::cnt_t             count_reg, count_next;
    logic                      found_reg, found_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [ple_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic [CW-1:0]  cnt_w, pos_w;
    logic           full, empty, pos_in_list, pos_for_ins;
    logic           ins_ok, pos_ok, key_op, del_req;
    ple_pkg::pos_t  ins_pos;
    ple_pkg::status_t status;

    ple_pkg::cell_ctrl_t ctrl;
    ple_pkg::key_t       keys [ple_pkg::CAPACITY];
    ple_pkg::val_t       vals [ple_pkg::CAPACITY];
    logic [ple_pkg::CAPACITY-1:0] hit, sel, ge;
    logic                         sel_any;
    ple_pkg::pos_t g_pos;
    ple_pkg::key_t g_key;
    ple_pkg::val_t g_val;

    logic          accept, load_out;
    ple_pkg::pos_t res_pos;
    ple_pkg::key_t res_key;
    ple_pkg::val_t res_val;

    assign accept = s_tvalid && s_tready;

    // request decode on the latched word
    always_comb
    begin
        cnt_w       = CW'(count_reg);
        pos_w       = CW'(pos_reg);
        full        = (cnt_w >= CW'(ple_pkg::CAPACITY));
        empty       = (count_reg == '0);
        pos_in_list = (pos_w != '0) && (pos_w <= cnt_w);
        pos_for_ins = (pos_w != '0) && (pos_w <= cnt_w + CW'(1));
        ins_ok      = 1'b0;
        pos_ok      = 1'b0;
        key_op      = 1'b0;
        del_req     = 1'b0;
        ins_pos     = '0;
        status      = ple_pkg::ST_BADPOS;
        case (req_reg)
            ple_pkg::REQ_APPEND:
            begin
                if (full)
                    status = ple_pkg::ST_FULL;
                else
                begin
                    ins_ok  = 1'b1;
                    ins_pos = ple_pkg::POS_W'(cnt_w + CW'(1));
                    status  = ple_pkg::ST_OK;
                end
            end
            ple_pkg::REQ_INSERT:
            begin
                if (full)
                    status = ple_pkg::ST_FULL;
                else if (!pos_for_ins)
                    status = ple_pkg::ST_BADPOS;
                else
                begin
                    ins_ok  = 1'b1;
                    ins_pos = pos_reg;
                    status  = ple_pkg::ST_OK;
                end
            end
            ple_pkg::REQ_REMOVE_AT, ple_pkg::REQ_READ:
            begin
                del_req = (req_reg == ple_pkg::REQ_REMOVE_AT);
                if (empty)
                    status = ple_pkg::ST_EMPTY;
                else if (!pos_in_list)
                    status = ple_pkg::ST_BADPOS;
                else
                begin
                    pos_ok = 1'b1;
                    status = ple_pkg::ST_OK;
                end
            end
            ple_pkg::REQ_REMOVE_KEY, ple_pkg::REQ_SEARCH:
            begin
                del_req = (req_reg == ple_pkg::REQ_REMOVE_KEY);
                if (empty)
                    status = ple_pkg::ST_EMPTY;
                else
                begin
                    key_op = 1'b1;
                    status = found_reg ? ple_pkg::ST_OK : ple_pkg::ST_NOKEY;
                end
            end
            default:
            begin
                status = ple_pkg::ST_BADPOS;
            end
        endcase
    end

    always_comb
    begin
        ctrl.ins_en     = (state_reg == ple_pkg::S_CMP) && ins_ok;
        ctrl.ins_idx    = ple_pkg::IDX_W'(ins_pos - ple_pkg::POS_W'(1));
        ctrl.new_key    = key_reg;
        ctrl.new_val    = val_reg;
        ctrl.del_en     = (state_reg == ple_pkg::S_GATH) && del_req
                          && (pos_ok || (key_op && sel_any));
        ctrl.hit_key_en = (state_reg == ple_pkg::S_CMP) && key_op;
        ctrl.hit_pos_en = (state_reg == ple_pkg::S_CMP) && pos_ok;
        ctrl.pos_idx    = ple_pkg::IDX_W'(pos_reg - ple_pkg::POS_W'(1));
        ctrl.count      = count_reg;
    end

    for (genvar i = 0; i < ple_pkg::CAPACITY; i++)
    begin : g_cell
        ple_pkg::key_t lo_key, up_key;
        ple_pkg::val_t lo_val, up_val;
        if (i == 0)
        begin : g_first
            assign lo_key = '0;
            assign lo_val = '0;
        end
        else
        begin : g_mid_lo
            assign lo_key = keys[i-1];
            assign lo_val = vals[i-1];
        end
        if (i == ple_pkg::CAPACITY - 1)
        begin : g_last
            assign up_key = '0;
            assign up_val = '0;
        end
        else
        begin : g_mid_up
            assign up_key = keys[i+1];
            assign up_val = vals[i+1];
        end

        ple_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (ple_pkg::IDX_W'(i)),
            .ctrl      (ctrl),
            .lower_key (lo_key),
            .lower_val (lo_val),
            .upper_key (up_key),
            .upper_val (up_val),
            .ge        (ge[i]),
            .key       (keys[i]),
            .val       (vals[i]),
            .hit       (hit[i])
        );
    end

    ple_select u_select
    (
        .clk   (clk),
        .rst_n (rst_n),
        .hit   (hit),
        .sel   (sel),
        .ge    (ge),
        .any   (sel_any)
    );

    ple_gather u_gather
    (
        .clk  (clk),
        .en   (state_reg == ple_pkg::S_GATH),
        .sel  (sel),
        .keys (keys),
        .vals (vals),
        .pos  (g_pos),
        .key  (g_key),
        .val  (g_val)
    );

    // sequencer and output register
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        found_next    = found_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        load_out      = 1'b0;
        res_pos       = '0;
        res_key       = '0;
        res_val       = '0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = ple_pkg::S_CMP;
            end
            ple_pkg::S_CMP:
            begin
                state_next = ple_pkg::S_GRP;
            end
            ple_pkg::S_GRP:
            begin
                state_next = ple_pkg::S_SEL;
            end
            ple_pkg::S_SEL:
            begin
                state_next = ple_pkg::S_GATH;
            end
            ple_pkg::S_GATH:
            begin
                found_next = sel_any;
                state_next = ple_pkg::S_DONE;
            end
            ple_pkg::S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ple_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase

        if (status == ple_pkg::ST_OK)
        begin
            if (ins_ok)
                res_pos = ins_pos;
            else
            begin
                res_pos = g_pos;
                res_key = g_key;
                res_val = g_val;
            end
        end

        if (load_out)
        begin
            if (ins_ok)
                count_next = count_reg + ple_pkg::CNT_W'(1);
            else if (del_req && (status == ple_pkg::ST_OK))
                count_next = count_reg - ple_pkg::CNT_W'(1);
            m_tvalid_next = 1'b1;
            m_tdata_next  = ple_pkg::OUT_W'({ple_pkg::POS_W'(count_next), res_val,
                                             res_key, res_pos, status});
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= s_tdata[2:0];
            pos_reg <= s_tdata[10:3];
            key_reg <= s_tdata[42:11];
            val_reg <= s_tdata[106:43];
        end
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ple_pkg::S_IDLE;
            count_reg    <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ple_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_engine: drives list requests on the input
// stream, predicts every answer with a behavioral list model, and checks each answer word.
// Depends on ple_pkg and the positional_list_engine RTL.
module testbench;
    import ple_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [IN_W-1:0] in_word_t;

    typedef struct {
        status_t status;
        pos_t    fpos;
        key_t    rkey;
        val_t    rval;
        pos_t    count;
    } list_answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    // shadow copy of the list
    key_t list_keys [CAPACITY];
    val_t list_vals [CAPACITY];
    int   list_count = 0;

    list_answer_t awaited_answers[$];
    int           mismatch_count = 0;
    bit           sender_gaps = 1'b1;
    int           ready_left = 0;

    positional_list_engine i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void drop_entry(int idx);
        for (int i = idx; i + 1 < list_count; i++)
        begin
            list_keys[i] = list_keys[i + 1];
            list_vals[i] = list_vals[i + 1];
        end
        list_count--;
    endfunction

    // Updates the shadow list and returns the answer the block must give.
    function automatic list_answer_t answer_request(logic [REQ_W-1:0] req, pos_t pos,
                                                    key_t key, val_t val);
        list_answer_t ans;
        int p;
        int hit;
        ans.status = ST_OK;
        ans.fpos   = '0;
        ans.rkey   = '0;
        ans.rval   = '0;
        p = pos;
        case (req)
            REQ_APPEND:
            begin
                if (list_count >= CAPACITY)
                    ans.status = ST_FULL;
                else
                begin
                    list_keys[list_count] = key;
                    list_vals[list_count] = val;
                    list_count++;
                    ans.fpos = pos_t'(list_count);
                end
            end
            REQ_INSERT:
            begin
                // full is checked ahead of the position
                if (list_count >= CAPACITY)
                    ans.status = ST_FULL;
                else if (p < 1 || p > list_count + 1)
                    ans.status = ST_BADPOS;
                else
                begin
                    for (int i = list_count; i >= p; i--)
                    begin
                        list_keys[i] = list_keys[i - 1];
                        list_vals[i] = list_vals[i - 1];
                    end
                    list_keys[p - 1] = key;
                    list_vals[p - 1] = val;
                    list_count++;
                    ans.fpos = pos;
                end
            end
            REQ_REMOVE_AT, REQ_READ:
            begin
                if (list_count == 0)
                    ans.status = ST_EMPTY;
                else if (p < 1 || p > list_count)
                    ans.status = ST_BADPOS;
                else
                begin
                    ans.fpos = pos;
                    ans.rkey = list_keys[p - 1];
                    ans.rval = list_vals[p - 1];
                    if (req == REQ_REMOVE_AT)
                        drop_entry(p - 1);
                end
            end
            REQ_REMOVE_KEY, REQ_SEARCH:
            begin
                if (list_count == 0)
                    ans.status = ST_EMPTY;
                else
                begin
                    hit = 0;
                    while (hit < list_count && list_keys[hit] != key)
                        hit++;
                    if (hit >= list_count)
                        ans.status = ST_NOKEY;
                    else
                    begin
                        ans.fpos = pos_t'(hit + 1);
                        ans.rkey = list_keys[hit];
                        ans.rval = list_vals[hit];
                        if (req == REQ_REMOVE_KEY)
                            drop_entry(hit);
                    end
                end
            end
            default:
                ans.status = ST_BADPOS;
        endcase
        ans.count = pos_t'(list_count);
        return ans;
    endfunction

    function automatic val_t rand_value();
        return {$urandom, $urandom};
    endfunction

    function automatic int random_gap();
        int r;
        if (!sender_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic idle_sender(int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Sends one request word after a random gap; predicts its answer on acceptance.
    // tvalid stays high on return, so the caller must send again or idle next.
    task automatic send_request(logic [REQ_W-1:0] req, pos_t pos, key_t key, val_t val);
        idle_sender(random_gap());
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= in_word_t'({val, key, pos, req});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        awaited_answers.push_back(answer_request(req, pos, key, val));
    endtask

    task automatic wait_answers_drained();
        idle_sender(1);
        while (awaited_answers.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: alternating ready runs and stalls, now and then a long stall-free run.
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            if (m_tready)
            begin
                m_tready   <= 1'b0;
                ready_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                           : $urandom_range(10, 40);
            end
            else
            begin
                m_tready   <= 1'b1;
                ready_left <= ($urandom_range(0, 9) < 2) ? $urandom_range(60, 200)
                                                         : $urandom_range(0, 7);
            end
        end
        else
            ready_left <= ready_left - 1;
    end

    always @(posedge clk)
    begin : answer_check
        list_answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_answers.size() == 0)
                report_mismatch("unexpected answer word", m_tdata[63:0], '0);
            else
            begin
                want = awaited_answers.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch("status", m_tdata[2:0], want.status);
                if (m_tdata[10:3] !== want.fpos)
                    report_mismatch("found_position", m_tdata[10:3], want.fpos);
                if (m_tdata[42:11] !== want.rkey)
                    report_mismatch("read_key", m_tdata[42:11], want.rkey);
                if (m_tdata[106:43] !== want.rval)
                    report_mismatch("read_value", m_tdata[106:43], want.rval);
                if (m_tdata[114:107] !== want.count)
                    report_mismatch("entry_count", m_tdata[114:107], want.count);
            end
        end
    end

    task automatic test_empty_list();
        send_request(REQ_REMOVE_AT, 8'd1, $urandom, rand_value());
        send_request(REQ_REMOVE_KEY, 8'd0, $urandom, rand_value());
        send_request(REQ_SEARCH, 8'd0, 32'h0, rand_value());
        send_request(REQ_READ, 8'd1, $urandom, rand_value());
        send_request(REQ_READ, 8'd0, $urandom, rand_value());
        send_request(REQ_INSERT, 8'd0, $urandom, rand_value());
        send_request(REQ_INSERT, 8'd2, $urandom, rand_value());
        send_request(REQ_UNUSED_LO, 8'hFF, 32'hFFFF_FFFF, '1);
        send_request(REQ_UNUSED_HI, pos_t'($urandom_range(0, 255)), $urandom, rand_value());
    endtask

    task automatic test_basic_edits();
        key_t ka;
        key_t kb;
        key_t kc;
        ka = 32'h0000_0001;
        kb = 32'h8000_0000;
        kc = 32'h5A5A_5A5A;
        send_request(REQ_APPEND, 8'd0, 32'h0, 64'h0);
        send_request(REQ_APPEND, 8'hFF, 32'hFFFF_FFFF, '1);
        send_request(REQ_INSERT, 8'd1, ka, rand_value());
        send_request(REQ_INSERT, pos_t'(list_count + 1), kb, rand_value());
        // second copy of ka further down: searches must find the first one
        send_request(REQ_INSERT, 8'd3, ka, rand_value());
        send_request(REQ_INSERT, 8'd0, kc, rand_value());
        send_request(REQ_INSERT, pos_t'(list_count + 2), kc, rand_value());
        send_request(REQ_INSERT, 8'd255, kc, rand_value());
        send_request(REQ_READ, 8'd1, kc, rand_value());
        send_request(REQ_READ, pos_t'(list_count), kc, rand_value());
        send_request(REQ_READ, 8'd0, kc, rand_value());
        send_request(REQ_READ, pos_t'(list_count + 1), kc, rand_value());
        send_request(REQ_READ, 8'd255, kc, rand_value());
        send_request(REQ_SEARCH, 8'd0, ka, rand_value());
        send_request(REQ_SEARCH, 8'd0, kc, rand_value());
        send_request(REQ_REMOVE_KEY, 8'd0, ka, rand_value());
        send_request(REQ_SEARCH, 8'd0, ka, rand_value());
        send_request(REQ_REMOVE_KEY, 8'd0, kc, rand_value());
        send_request(REQ_REMOVE_AT, 8'd0, kc, rand_value());
        send_request(REQ_REMOVE_AT, pos_t'(list_count + 1), kc, rand_value());
        send_request(REQ_REMOVE_AT, pos_t'(list_count), kc, rand_value());
        send_request(REQ_REMOVE_AT, 8'd1, kc, rand_value());
    endtask

    task automatic test_full_list();
        while (list_count < CAPACITY)
        begin
            if ($urandom_range(0, 1))
                send_request(REQ_APPEND, pos_t'($urandom_range(0, 255)), $urandom,
                             rand_value());
            else
                send_request(REQ_INSERT, pos_t'($urandom_range(1, list_count + 1)), $urandom,
                             rand_value());
        end
        send_request(REQ_APPEND, 8'd0, $urandom, rand_value());
        send_request(REQ_INSERT, 8'd1, $urandom, rand_value());
        send_request(REQ_INSERT, 8'd0, $urandom, rand_value());
        send_request(REQ_INSERT, 8'd200, $urandom, rand_value());
        send_request(REQ_READ, pos_t'(CAPACITY), $urandom, rand_value());
        send_request(REQ_READ, pos_t'(CAPACITY + 1), $urandom, rand_value());
        send_request(REQ_SEARCH, 8'd0, list_keys[CAPACITY - 1], rand_value());
        send_request(REQ_REMOVE_AT, pos_t'(CAPACITY), $urandom, rand_value());
        send_request(REQ_INSERT, pos_t'(CAPACITY), $urandom, rand_value());
        send_request(REQ_REMOVE_KEY, 8'd0, list_keys[CAPACITY / 2], rand_value());
        send_request(REQ_INSERT, 8'd1, $urandom, rand_value());
        while (list_count > 40)
            send_request(REQ_REMOVE_AT, pos_t'($urandom_range(1, list_count)), $urandom,
                         rand_value());
    endtask

    function automatic logic [REQ_W-1:0] pick_request(bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return $urandom_range(0, 1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
        if (grow)
        begin
            if (r < 33) return REQ_APPEND;
            if (r < 60) return REQ_INSERT;
            if (r < 68) return REQ_REMOVE_AT;
            if (r < 76) return REQ_REMOVE_KEY;
            if (r < 88) return REQ_SEARCH;
            return REQ_READ;
        end
        if (r < 8)  return REQ_APPEND;
        if (r < 13) return REQ_INSERT;
        if (r < 43) return REQ_REMOVE_AT;
        if (r < 68) return REQ_REMOVE_KEY;
        if (r < 84) return REQ_SEARCH;
        return REQ_READ;
    endfunction

    task automatic test_random_traffic();
        key_t key_pool [8];
        int   targets [5];
        int   target;
        logic [REQ_W-1:0] req;
        pos_t pos;
        key_t key;
        targets = '{1, 8, 40, 100, CAPACITY};
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            key_pool[i] = $urandom;
        target = CAPACITY;
        for (int n = 0; n < 650; n++)
        begin
            if (n % 75 == 0)
            begin
                target = targets[$urandom_range(0, 4)];
                sender_gaps = ($urandom_range(0, 3) != 0);
            end
            if (n == 325)
                wait_answers_drained();
            req = pick_request(list_count < target);
            // mostly legal positions, the rest anywhere in the field
            if ($urandom_range(0, 99) < 15 || req == REQ_APPEND)
                pos = pos_t'($urandom_range(0, 255));
            else if (req == REQ_INSERT)
                pos = pos_t'($urandom_range(1, list_count + 1));
            else if (list_count == 0)
                pos = 8'd1;
            else
                pos = pos_t'($urandom_range(1, list_count));
            if ((req == REQ_SEARCH || req == REQ_REMOVE_KEY) && list_count > 0
                && $urandom_range(0, 99) < 60)
                key = list_keys[$urandom_range(0, list_count - 1)];
            else if ($urandom_range(0, 99) < 70)
                key = key_pool[$urandom_range(0, 7)];
            else
                key = $urandom;
            send_request(req, pos, key, rand_value());
        end
        sender_gaps = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_list();
        test_basic_edits();
        test_full_list();
        test_random_traffic();
        wait_answers_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/ple_select.sv
rtl/core/ple_gather.sv
rtl/core/positional_list_engine.sv
test/testbench.sv
